// ----- rtl/oll_pkg.sv -----
// ----------------------------------------------------------------------------
// oll_pkg: shared types for the ordered list block
// Request and response payloads, codes, and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package oll_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 32;
  localparam int unsigned VALUE_W         = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_DUMP   = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_EMPTY_DELETE = 3'd2,
    ST_FULL         = 3'd3,
    ST_DUMP_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic [2:0]                status;
    logic                      last;
  } resp_t;

  // broadcast to every cell
  typedef struct packed {
    logic                      cap;  // latch compare result
    logic                      ins;  // shift toward the tail
    logic                      del;  // close the gap at the first match
    logic                      rot;  // rotate the occupied part by one
    logic signed [VALUE_W-1:0] key;  // insert value / delete key
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/ordered_list_push_delete_dump.sv -----
// ----------------------------------------------------------------------------
// ordered_list_push_delete_dump: bounded ordered list in a chain of cells
// Insert at front, delete first match, dump front to back.
// ----------------------------------------------------------------------------
//
//  channel | ports                              | payload
//  --------+------------------------------------+---------------------------
//  request | in_valid_i / in_ready_o            | in_data_i  (req_t)
//  result  | out_valid_o / out_ready_i          | out_data_o (resp_t)
//
//  Insert: the chain shifts at the accepting edge, result registered.
//  Delete: compare in every cell, then a prefix-OR along the chain
//          picks the first match and the cells behind it shift forward.
//  Dump:   for N entries, one rotation of the chain per result;
//          after N rotations the list is back in order.
//  Reset clears the count and the control; cell contents stay undefined.
//  A stalled result holds the block: a request is taken only from idle and
//  only when the output register is free or being emptied.
//
`default_nettype none

module ordered_list_push_delete_dump
  import oll_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire req_t  in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output resp_t      out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEL  = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;    // results left in the dump
  logic            out_valid_q, out_valid_d;
  resp_t           out_q, out_d;

  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] cell_val [MAX_ENTRIES];
  logic [MAX_ENTRIES:0]      found;
  logic [MAX_ENTRIES-1:0]    occ, tail;

  logic out_free, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---- cell chain ----
  assign found[0] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left, right;

    assign occ[i]  = CntW'(i) < count_q;
    assign tail[i] = CntW'(i + 1) == count_q;

    if (i == 0) begin : g_front
      assign left = ctrl.key;
    end else begin : g_mid
      assign left = cell_val[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_end
      assign right = cell_val[i];
    end else begin : g_inner
      assign right = cell_val[i+1];
    end

    oll_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .occ_i   (occ[i]),
      .tail_i  (tail[i]),
      .left_i  (left),
      .right_i (right),
      .head_i  (cell_val[0]),
      .found_i (found[i]),
      .found_o (found[i+1]),
      .value_o (cell_val[i])
    );
  end

  // ---- control ----
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctrl        = '0;
    ctrl.key    = in_data_i.item_value;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_d.out_value = '0;
          out_d.last      = 1'b1;
          unique case (in_data_i.req_type)
            REQ_INSERT: begin
              out_valid_d = 1'b1;
              if (count_q >= CntW'(MAX_ENTRIES)) begin
                out_d.status = ST_FULL;
              end else begin
                ctrl.ins     = 1'b1;
                count_d      = count_q + 1'b1;
                out_d.status = ST_OK;
              end
            end
            REQ_DELETE: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = ST_EMPTY_DELETE;
              end else begin
                ctrl.cap = 1'b1;
                state_d  = S_DEL;
              end
            end
            REQ_DUMP: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = ST_DUMP_EMPTY;
              end else begin
                rem_d   = count_q;
                state_d = S_DUMP;
              end
            end
            default: begin
              // unused code: dropped without a result
            end
          endcase
        end
      end
      S_DEL: begin
        if (out_free) begin
          ctrl.del        = 1'b1;
          out_valid_d     = 1'b1;
          out_d.out_value = '0;
          out_d.last      = 1'b1;
          if (found[MAX_ENTRIES]) begin
            count_d      = count_q - 1'b1;
            out_d.status = ST_OK;
          end else begin
            out_d.status = ST_NOT_FOUND;
          end
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctrl.rot        = 1'b1;
          out_valid_d     = 1'b1;
          out_d.out_value = cell_val[0];
          out_d.status    = ST_OK;
          out_d.last      = (rem_q == CntW'(1));
          rem_d           = rem_q - 1'b1;
          if (rem_q == CntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/oll_cell.sv -----
// ----------------------------------------------------------------------------
// oll_cell: one list cell
// Holds one entry, compares it with the key, and moves data to or from its
// neighbors on insert, delete and dump rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module oll_cell
  import oll_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire cell_ctrl_t                ctrl_i,
  input  wire logic                      occ_i,    // cell below the count
  input  wire logic                      tail_i,   // last occupied cell
  input  wire logic signed [VALUE_W-1:0] left_i,   // toward the front
  input  wire logic signed [VALUE_W-1:0] right_i,  // toward the tail
  input  wire logic signed [VALUE_W-1:0] head_i,
  input  wire logic                      found_i,  // match somewhere in front
  output logic                           found_o,
  output logic signed [VALUE_W-1:0]      value_o
);

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      match_q;

  assign found_o = found_i | match_q;
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      value_d = left_i;
    end else if (ctrl_i.del && found_o) begin
      value_d = right_i;
    end else if (ctrl_i.rot) begin
      value_d = tail_i ? head_i : right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (ctrl_i.cap) begin
      match_q <= occ_i && (value_q == ctrl_i.key);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/oll_checker.sv -----
// ----------------------------------------------------------------------------
// oll_checker: port-level checks for the ordered list block
// Watches both channels and flags ordering and framing errors.
// ----------------------------------------------------------------------------
`default_nettype none

module oll_checker
  import oll_pkg::*;
(
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  in_valid_i,
  input wire logic  in_ready_o,
  input wire req_t  in_data_i,
  input wire logic  out_valid_o,
  input wire logic  out_ready_i,
  input wire resp_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // no request taken while a result is stuck
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while output stalled");

  // insert answers in the next cycle with a single zero-valued result
  a_insert_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.req_type == REQ_INSERT)
    |=> out_valid_o && out_data_o.last && (out_data_o.out_value == '0))
    else $error("insert result missing or malformed");

  // error status only on a single, zero-valued result
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK)
    |-> out_data_o.last && (out_data_o.out_value == '0))
    else $error("error status on a non-final or non-zero result");

endmodule

bind ordered_list_push_delete_dump oll_checker u_oll_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: ordered list block, insert / delete / dump
// Queue-fed driver and a checking monitor. A shadow list predicts every
// response at request acceptance. Both sides idle in short random bursts.
// ----------------------------------------------------------------------------

module testbench;
  import oll_pkg::*;

  localparam int unsigned LIST_DEPTH   = 32;
  localparam int unsigned RANDOM_ITEMS = 392;
  localparam int unsigned TAIL_ITEMS   = 40;      // no idling once this few remain
  localparam int unsigned HOLD_AT      = 60;      // response count that starts the long hold
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned PRINT_CAP    = 50;

  // request code the block must ignore without a response
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    req_t req;
    bit   wait_empty;   // hold the request back until nothing is outstanding
  } pending_req_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  req_t  in_data_i   = '0;
  logic  out_ready_i = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  resp_t out_data_o;

  ordered_list_push_delete_dump #(
    .MAX_ENTRIES(LIST_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow list and expected responses
  // --------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] list_cells[$];   // index 0 is the front
  resp_t                     resp_expect_q[$];
  pending_req_t              req_pending_q[$];
  int unsigned               error_count = 0;

  task automatic flag_error(input string msg);
    if (error_count < PRINT_CAP)
      $display("%0t ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Apply one accepted request to the shadow list and queue its responses.
  task automatic predict_list_op(input req_t r);
    resp_t e;
    int    hit;
    e   = '0;
    hit = -1;
    e.last = 1'b1;
    case (r.req_type)
      REQ_INSERT: begin
        if (list_cells.size() >= LIST_DEPTH) begin
          e.status = ST_FULL;         // value dropped, list untouched
        end else begin
          list_cells.push_front(r.item_value);
          e.status = ST_OK;
        end
        resp_expect_q.push_back(e);
      end
      REQ_DELETE: begin
        if (list_cells.size() == 0) begin
          e.status = ST_EMPTY_DELETE;
        end else begin
          // only the match nearest the front goes
          foreach (list_cells[i])
            if (hit < 0 && list_cells[i] == r.item_value) hit = i;
          if (hit >= 0) begin
            list_cells.delete(hit);
            e.status = ST_OK;
          end else begin
            e.status = ST_NOT_FOUND;
          end
        end
        resp_expect_q.push_back(e);
      end
      REQ_DUMP: begin
        if (list_cells.size() == 0) begin
          e.status = ST_DUMP_EMPTY;
          resp_expect_q.push_back(e);
        end else begin
          foreach (list_cells[i]) begin
            e.out_value = list_cells[i];
            e.status    = ST_OK;
            e.last      = (i == list_cells.size() - 1);
            resp_expect_q.push_back(e);
          end
        end
      end
      default: ;                      // unused code: no response, no change
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: pops the pending queue, keeps valid and payload stable until the
  // transaction is taken, and inserts idle bursts between transactions.
  // --------------------------------------------------------------------------
  bit send_offer;
  int send_gap     = 0;
  bit send_idle_en = 1'b1;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap    = 0;
    end else begin
      send_offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_list_op(in_data_i);
        send_offer = 1'b0;
        if (send_idle_en && req_pending_q.size() >= TAIL_ITEMS &&
            $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 5);
      end
      if (!send_offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_pending_q.size() != 0 &&
                     (!req_pending_q[0].wait_empty || resp_expect_q.size() == 0)) begin
          in_data_i <= req_pending_q[0].req;
          void'(req_pending_q.pop_front());
          send_offer = 1'b1;
        end
      end
      // alternate between bursty stretches and stretches at full rate
      if ($urandom_range(0, 63) == 0) send_idle_en = !send_idle_en;
      in_valid_i <= send_offer;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each response transaction against the oldest expectation
  // and drives ready, including one long hold-off that backs up the block.
  // --------------------------------------------------------------------------
  resp_t       resp_exp;
  bit          recv_ready;
  int          recv_gap     = 0;
  int          hold_left    = 0;
  bit          recv_idle_en = 1'b1;
  int unsigned resp_seen    = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap     = 0;
      hold_left    = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (resp_expect_q.size() == 0) begin
          flag_error($sformatf("unexpected response value=%0d status=%0d last=%0b",
                               out_data_o.out_value, out_data_o.status,
                               out_data_o.last));
        end else begin
          resp_exp = resp_expect_q.pop_front();
          if (out_data_o.out_value !== resp_exp.out_value)
            flag_error($sformatf("response %0d: out_value %0d, expected %0d", resp_seen,
                                 out_data_o.out_value, resp_exp.out_value));
          if (out_data_o.status !== resp_exp.status)
            flag_error($sformatf("response %0d: status %0d, expected %0d", resp_seen,
                                 out_data_o.status, resp_exp.status));
          if (out_data_o.last !== resp_exp.last)
            flag_error($sformatf("response %0d: last %0b, expected %0b", resp_seen,
                                 out_data_o.last, resp_exp.last));
        end
        resp_seen++;
        if (resp_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end

      if (hold_left > 0) begin
        hold_left--;
        recv_ready = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        recv_ready = 1'b0;
      end else if (recv_idle_en && req_pending_q.size() >= TAIL_ITEMS &&
                   $urandom_range(0, 5) == 0) begin
        recv_gap   = $urandom_range(0, 4);   // idle burst of random length
        recv_ready = 1'b0;
      end else begin
        recv_ready = 1'b1;
      end
      if ($urandom_range(0, 63) == 0) recv_idle_en = !recv_idle_en;
      out_ready_i <= recv_ready;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] value_pool[0:11];
  int unsigned               counted = 0;

  task automatic queue_req(input logic [1:0] kind, input logic signed [VALUE_W-1:0] val,
                           input bit wait_empty = 1'b0);
    pending_req_t p;
    p.req.req_type   = kind;
    p.req.item_value = val;
    p.wait_empty     = wait_empty;
    req_pending_q.push_back(p);
    if (kind != REQ_UNUSED) counted++;
  endtask

  // mostly pool values so that deletes hit and duplicates appear
  function automatic logic signed [VALUE_W-1:0] pick_value(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct)
      return value_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  int seg_mode;
  int seg_len;
  int pick;

  initial begin
    value_pool[0] = 32'sh7FFF_FFFF;
    value_pool[1] = 32'sh8000_0000;
    value_pool[2] = 32'sh0000_0000;
    value_pool[3] = -32'sd1;
    value_pool[4] = 32'sd1;
    for (int i = 5; i < 12; i++) value_pool[i] = $urandom;

    // directed: empty cases, extremes, duplicates, first-match delete
    queue_req(REQ_DUMP,   $urandom);               // dump of empty list
    queue_req(REQ_DELETE, 32'sd5);                 // delete on empty list
    queue_req(REQ_UNUSED, 32'sd0);                 // ignored code
    queue_req(REQ_INSERT, 32'sh7FFF_FFFF);
    queue_req(REQ_INSERT, 32'sh8000_0000);
    queue_req(REQ_INSERT, 32'sd0);
    queue_req(REQ_INSERT, -32'sd1);
    queue_req(REQ_INSERT, 32'sd7);
    queue_req(REQ_INSERT, 32'sd7);
    queue_req(REQ_INSERT, 32'sh8000_0000);
    queue_req(REQ_DUMP,   32'sd0);
    queue_req(REQ_DELETE, 32'sd7);                 // two matches, front one goes
    queue_req(REQ_DELETE, 32'sd12345);             // no match
    queue_req(REQ_DELETE, 32'sh8000_0000);         // matches at front and deeper
    queue_req(REQ_DELETE, 32'sh7FFF_FFFF);         // tail entry
    queue_req(REQ_DUMP,   -32'sd1);
    queue_req(REQ_UNUSED, $urandom);
    queue_req(REQ_DUMP,   $urandom, 1'b1);

    // random segments with a bias per segment so the list fills and drains
    while (counted < RANDOM_ITEMS) begin
      seg_mode = $urandom_range(0, 3);
      seg_len  = (seg_mode == 0) ? $urandom_range(30, 42) : $urandom_range(8, 30);
      for (int k = 0; k < seg_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          queue_req(REQ_UNUSED, $urandom, k == 0 && $urandom_range(0, 4) == 0);
        end else begin
          pick = $urandom_range(0, 99);
          case (seg_mode)
            0: begin                                  // fill past full
              if (pick < 94) queue_req(REQ_INSERT, pick_value(60));
              else           queue_req(REQ_DUMP, $urandom);
            end
            1: begin                                  // drain
              if (pick < 78)      queue_req(REQ_DELETE, pick_value(85));
              else if (pick < 88) queue_req(REQ_INSERT, pick_value(85));
              else                queue_req(REQ_DUMP, $urandom);
            end
            2: begin                                  // mixed
              if (pick < 45)      queue_req(REQ_INSERT, pick_value(70));
              else if (pick < 85) queue_req(REQ_DELETE, pick_value(70));
              else                queue_req(REQ_DUMP, $urandom);
            end
            default: begin                            // dump heavy
              if (pick < 50)      queue_req(REQ_INSERT, pick_value(50));
              else if (pick < 70) queue_req(REQ_DELETE, pick_value(70));
              else                queue_req(REQ_DUMP, $urandom,
                                            $urandom_range(0, 7) == 0);
            end
          endcase
        end
      end
    end

    // reset once, released away from the active edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_pending_q.size() != 0 || in_valid_i || resp_expect_q.size() != 0)
      @(posedge clk_i);
    // anything extra the block still emits is flagged by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  int unsigned cycle_count = 0;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t ERROR: timeout with %0d responses outstanding", $time,
             resp_expect_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
